// ===== hdl/aor_pkg.sv =====
package aor_pkg;

    localparam int CENTRE_W = 32;
    localparam int SIZE_W   = 31;
    localparam int EDGE_W   = 34;
    localparam int DIFF_W   = 35;
    localparam int SUM_W    = 37;
    localparam int MAG_W    = SUM_W - 1;
    localparam int PUSH_W   = 34;
    localparam int CODE_W   = 4;

    // side code bit positions
    localparam int SIDE_ABOVE = 0;
    localparam int SIDE_RIGHT = 1;
    localparam int SIDE_BELOW = 2;
    localparam int SIDE_LEFT  = 3;

    localparam logic signed [PUSH_W-1:0] PUSH_MAX = {1'b0, {(PUSH_W-1){1'b1}}};
    localparam logic signed [PUSH_W-1:0] PUSH_MIN = {1'b1, {(PUSH_W-1){1'b0}}};

    typedef struct packed {
        logic signed [CENTRE_W-1:0] a_center_x;
        logic signed [CENTRE_W-1:0] a_center_y;
        logic        [SIZE_W-1:0]   a_width;
        logic        [SIZE_W-1:0]   a_height;
        logic signed [CENTRE_W-1:0] b_center_x;
        logic signed [CENTRE_W-1:0] b_center_y;
        logic        [SIZE_W-1:0]   b_width;
        logic        [SIZE_W-1:0]   b_height;
    } pair_t;

    typedef struct packed {
        logic signed [EDGE_W-1:0] l1;
        logic signed [EDGE_W-1:0] r1;
        logic signed [EDGE_W-1:0] u1;
        logic signed [EDGE_W-1:0] d1;
        logic signed [EDGE_W-1:0] l2;
        logic signed [EDGE_W-1:0] r2;
        logic signed [EDGE_W-1:0] u2;
        logic signed [EDGE_W-1:0] d2;
    } edges_t;

    typedef struct packed {
        logic                     hit;
        logic [CODE_W-1:0]        code;
        logic signed [DIFF_W-1:0] dy_up;
        logic signed [DIFF_W-1:0] dx_right;
        logic signed [DIFF_W-1:0] dy_down;
        logic signed [DIFF_W-1:0] dx_left;
    } test_t;

    typedef struct packed {
        logic signed [PUSH_W-1:0] push_x;
        logic signed [PUSH_W-1:0] push_y;
        logic                     overlapping;
        logic [CODE_W-1:0]        side_code;
    } result_t;

    // centre in Q16.16 doubled to Q17.17
    function automatic logic signed [EDGE_W-1:0] centre_q17(input logic signed [CENTRE_W-1:0] c);
        return {{(EDGE_W-CENTRE_W-1){c[CENTRE_W-1]}}, c, 1'b0};
    endfunction

    function automatic logic signed [EDGE_W-1:0] size_q17(input logic [SIZE_W-1:0] s);
        return {{(EDGE_W-SIZE_W){1'b0}}, s};
    endfunction

    function automatic logic signed [DIFF_W-1:0] edge_diff(input logic signed [EDGE_W-1:0] p,
                                                           input logic signed [EDGE_W-1:0] q);
        logic signed [DIFF_W-1:0] pe;
        logic signed [DIFF_W-1:0] qe;
        pe = {{(DIFF_W-EDGE_W){p[EDGE_W-1]}}, p};
        qe = {{(DIFF_W-EDGE_W){q[EDGE_W-1]}}, q};
        return pe - qe;
    endfunction

    function automatic logic signed [SUM_W-1:0] diff_ext(input logic signed [DIFF_W-1:0] d);
        return {{(SUM_W-DIFF_W){d[DIFF_W-1]}}, d};
    endfunction

    // both offsets stay when the code is a multiple of five or has at most one bit
    function automatic logic keep_both(input logic [CODE_W-1:0] code);
        logic mult5;
        logic single;
        mult5  = (code[SIDE_ABOVE] == code[SIDE_BELOW]) && (code[SIDE_RIGHT] == code[SIDE_LEFT]);
        single = (code & (code - CODE_W'(1))) == '0;
        return mult5 || single;
    endfunction

    function automatic logic signed [PUSH_W-1:0] sat_push(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-PUSH_W){PUSH_MAX[PUSH_W-1]}}, PUSH_MAX};
        lo = {{(SUM_W-PUSH_W){PUSH_MIN[PUSH_W-1]}}, PUSH_MIN};
        if (v > hi)
        begin
            return PUSH_MAX;
        end
        else if (v < lo)
        begin
            return PUSH_MIN;
        end
        return v[PUSH_W-1:0];
    endfunction

endpackage

// ===== hdl/aor_edge.sv =====
module aor_edge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  aor_pkg::pair_t   in_pair,
    output logic             out_valid,
    input  logic             out_ready,
    output aor_pkg::edges_t  out_edges
);
    import aor_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    edges_t edges_reg;
    edges_t edges_next;

    logic signed [EDGE_W-1:0] ax;
    logic signed [EDGE_W-1:0] ay;
    logic signed [EDGE_W-1:0] bx;
    logic signed [EDGE_W-1:0] by;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        ax = centre_q17(in_pair.a_center_x);
        ay = centre_q17(in_pair.a_center_y);
        bx = centre_q17(in_pair.b_center_x);
        by = centre_q17(in_pair.b_center_y);
        // full size read as a Q17.17 half size
        edges_next.l1 = ax - size_q17(in_pair.a_width);
        edges_next.r1 = ax + size_q17(in_pair.a_width);
        edges_next.u1 = ay - size_q17(in_pair.a_height);
        edges_next.d1 = ay + size_q17(in_pair.a_height);
        edges_next.l2 = bx - size_q17(in_pair.b_width);
        edges_next.r2 = bx + size_q17(in_pair.b_width);
        edges_next.u2 = by - size_q17(in_pair.b_height);
        edges_next.d2 = by + size_q17(in_pair.b_height);
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            edges_reg <= edges_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_edges = edges_reg;

endmodule

// ===== hdl/aor_test.sv =====
module aor_test (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  aor_pkg::edges_t  in_edges,
    output logic             out_valid,
    input  logic             out_ready,
    output aor_pkg::test_t   out_test
);
    import aor_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    test_t test_reg;
    test_t test_next;
    logic  hit;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // touching edges count as overlap
        hit = (in_edges.l1 <= in_edges.r2) && (in_edges.r1 >= in_edges.l2) &&
              (in_edges.u1 <= in_edges.d2) && (in_edges.d1 >= in_edges.u2);
        test_next.hit                  = hit;
        test_next.code                 = '0;
        test_next.code[SIDE_ABOVE]     = hit && (in_edges.u1 < in_edges.u2);
        test_next.code[SIDE_RIGHT]     = hit && (in_edges.r1 > in_edges.r2);
        test_next.code[SIDE_BELOW]     = hit && (in_edges.d1 > in_edges.d2);
        test_next.code[SIDE_LEFT]      = hit && (in_edges.l1 < in_edges.l2);
        test_next.dy_up                = edge_diff(in_edges.d1, in_edges.u2);
        test_next.dx_right             = edge_diff(in_edges.r2, in_edges.l1);
        test_next.dy_down              = edge_diff(in_edges.d2, in_edges.u1);
        test_next.dx_left              = edge_diff(in_edges.r1, in_edges.l2);
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            test_reg <= test_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_test  = test_reg;

endmodule

// ===== hdl/aor_resolve.sv =====
module aor_resolve (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  aor_pkg::test_t   in_test,
    output logic             out_valid,
    input  logic             out_ready,
    output aor_pkg::result_t out_result
);
    import aor_pkg::*;

    // stage a: per-axis sums
    logic                    sum_valid_reg;
    logic                    sum_valid_next;
    logic                    sum_ready;
    logic signed [SUM_W-1:0] px_reg;
    logic signed [SUM_W-1:0] px_next;
    logic signed [SUM_W-1:0] py_reg;
    logic signed [SUM_W-1:0] py_next;
    logic                    sum_hit_reg;
    logic [CODE_W-1:0]       sum_code_reg;

    // stage b: magnitudes and saturated pushes
    logic                     mag_valid_reg;
    logic                     mag_valid_next;
    logic                     mag_ready;
    logic [MAG_W-1:0]         mag_x_reg;
    logic [MAG_W-1:0]         mag_x_next;
    logic [MAG_W-1:0]         mag_y_reg;
    logic [MAG_W-1:0]         mag_y_next;
    logic signed [PUSH_W-1:0] sat_x_reg;
    logic signed [PUSH_W-1:0] sat_y_reg;
    logic                     keep_reg;
    logic                     mag_hit_reg;
    logic [CODE_W-1:0]        mag_code_reg;

    // stage c: axis choice, output register
    logic    res_valid_reg;
    logic    res_valid_next;
    logic    res_ready;
    result_t res_reg;
    result_t res_next;

    logic signed [SUM_W-1:0] abs_x;
    logic signed [SUM_W-1:0] abs_y;

    assign res_ready = !res_valid_reg || out_ready;
    assign mag_ready = !mag_valid_reg || res_ready;
    assign sum_ready = !sum_valid_reg || mag_ready;
    assign in_ready  = sum_ready;

    always_comb
    begin
        px_next = (in_test.code[SIDE_RIGHT] ? diff_ext(in_test.dx_right) : '0) -
                  (in_test.code[SIDE_LEFT]  ? diff_ext(in_test.dx_left)  : '0);
        py_next = (in_test.code[SIDE_BELOW] ? diff_ext(in_test.dy_down)  : '0) -
                  (in_test.code[SIDE_ABOVE] ? diff_ext(in_test.dy_up)    : '0);
    end

    always_comb
    begin
        abs_x      = px_reg[SUM_W-1] ? -px_reg : px_reg;
        abs_y      = py_reg[SUM_W-1] ? -py_reg : py_reg;
        mag_x_next = abs_x[MAG_W-1:0];
        mag_y_next = abs_y[MAG_W-1:0];
    end

    always_comb
    begin
        res_next.push_x      = sat_x_reg;
        res_next.push_y      = sat_y_reg;
        res_next.overlapping = mag_hit_reg;
        res_next.side_code   = mag_code_reg;
        if (!keep_reg)
        begin
            // tie keeps the y push
            if (mag_x_reg < mag_y_reg)
            begin
                res_next.push_y = '0;
            end
            else
            begin
                res_next.push_x = '0;
            end
        end
    end

    assign sum_valid_next = sum_ready ? in_valid      : sum_valid_reg;
    assign mag_valid_next = mag_ready ? sum_valid_reg : mag_valid_reg;
    assign res_valid_next = res_ready ? mag_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            mag_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            mag_valid_reg <= mag_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && in_valid)
        begin
            px_reg       <= px_next;
            py_reg       <= py_next;
            sum_hit_reg  <= in_test.hit;
            sum_code_reg <= in_test.code;
        end
        if (mag_ready && sum_valid_reg)
        begin
            mag_x_reg    <= mag_x_next;
            mag_y_reg    <= mag_y_next;
            sat_x_reg    <= sat_push(px_reg);
            sat_y_reg    <= sat_push(py_reg);
            keep_reg     <= keep_both(sum_code_reg);
            mag_hit_reg  <= sum_hit_reg;
            mag_code_reg <= sum_code_reg;
        end
        if (res_ready && mag_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

endmodule

// ===== hdl/aabb_overlap_resolve.sv =====
// channel | dir | payload
// s_*     | in  | one box pair request: centres and sizes of boxes a and b
// m_*     | out | push offsets for box a, overlap flag and side code
//
// one box pair is taken every cycle while m_tready does not hold the output; a result passes through
// the register stages in order: edges, overlap test, axis sums, magnitudes, axis choice
// rst_n clears the stage valid bits only; the data registers keep whatever they hold
// each stage takes a new request when it is empty or its successor moves on,
// so empty stages close up behind a stalled output and nothing is dropped or repeated
module aabb_overlap_resolve (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_center_x, a_center_y, a_width, a_height, b_center_x, b_center_y, b_width, b_height
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // push_x, push_y, overlapping, side_code
    output logic [79:0]  m_tdata
);
    import aor_pkg::*;

    pair_t   pair;
    edges_t  edges;
    test_t   test_res;
    result_t res;
    logic    edge_valid;
    logic    edge_ready;
    logic    test_valid;
    logic    test_ready;

    assign pair.a_center_x = s_tdata[31:0];
    assign pair.a_center_y = s_tdata[63:32];
    assign pair.a_width    = s_tdata[94:64];
    assign pair.a_height   = s_tdata[125:95];
    assign pair.b_center_x = s_tdata[157:126];
    assign pair.b_center_y = s_tdata[189:158];
    assign pair.b_width    = s_tdata[220:190];
    assign pair.b_height   = s_tdata[251:221];

    aor_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pair   (pair),
        .out_valid (edge_valid),
        .out_ready (edge_ready),
        .out_edges (edges)
    );

    aor_test u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (edge_valid),
        .in_ready  (edge_ready),
        .in_edges  (edges),
        .out_valid (test_valid),
        .out_ready (test_ready),
        .out_test  (test_res)
    );

    aor_resolve u_resolve (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (test_valid),
        .in_ready   (test_ready),
        .in_test    (test_res),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tdata = {7'b0, res.side_code, res.overlapping, res.push_y, res.push_x};

`ifndef SYNTHESIS
    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.overlapping |->
            res.push_x == '0 && res.push_y == '0 && res.side_code == '0)
        else $error("push or side code set without overlap");

    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !keep_both(res.side_code) |-> res.push_x == '0 || res.push_y == '0)
        else $error("both axes kept for a mixed side code");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off while the pipeline can move");
`endif

endmodule
